// ===== design/sgr_pkg.sv =====
package sgr_pkg;

	localparam logic [7:0] CHAR_FIRST = 8'd32;
	localparam logic [7:0] CHAR_LAST = 8'd127;
	localparam logic [6:0] QMARK_IDX = 7'd31;
	localparam int FONT_COLS = 5;
	localparam int FONT_ROWS = 8;

	typedef struct packed {
		logic [7:0] char_code;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [7:0] magnify;
	} sgr_req_t;

	typedef struct packed {
		logic accepted;
		logic [9:0] win_x0;
		logic [9:0] win_y0;
		logic [9:0] win_x1;
		logic [9:0] win_y1;
		logic [4:0] row_index;
		logic [17:0] row_mask;
		logic [4:0] row_width;
		logic [15:0] out_fg;
		logic [15:0] out_bg;
		logic last;
	} sgr_rsp_t;

	typedef struct packed {
		logic rej;
		logic [1:0] sc;
		logic [39:0] glyph;
		logic [9:0] x0;
		logic [9:0] y0;
		logic [9:0] x1;
		logic [9:0] y1;
		logic [15:0] fg;
		logic [15:0] bg;
	} sgr_cmd_t;

	// Five font columns, leftmost column in the top byte, bit n of a byte is font row n.
	function automatic logic [39:0] glyph_rom(input logic [6:0] idx);
		logic [39:0] g;
		unique case (idx)
			7'd0: g = 40'h0000000000;
			7'd1: g = 40'h00005F0000;
			7'd2: g = 40'h0007000700;
			7'd3: g = 40'h147F147F14;
			7'd4: g = 40'h242A7F2A12;
			7'd5: g = 40'h2313086462;
			7'd6: g = 40'h3649552250;
			7'd7: g = 40'h0005030000;
			7'd8: g = 40'h001C224100;
			7'd9: g = 40'h0041221C00;
			7'd10: g = 40'h14083E0814;
			7'd11: g = 40'h08083E0808;
			7'd12: g = 40'h0050300000;
			7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0060600000;
			7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3E5149453E;
			7'd17: g = 40'h00427F4000;
			7'd18: g = 40'h4261514946;
			7'd19: g = 40'h2141454B31;
			7'd20: g = 40'h1814127F10;
			7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3C4A494930;
			7'd23: g = 40'h0171090503;
			7'd24: g = 40'h3649494936;
			7'd25: g = 40'h064949291E;
			7'd26: g = 40'h0036360000;
			7'd27: g = 40'h0056360000;
			7'd28: g = 40'h0814224100;
			7'd29: g = 40'h1414141414;
			7'd30: g = 40'h0041221408;
			7'd31: g = 40'h0201510906;
			7'd32: g = 40'h324979413E;
			7'd33: g = 40'h7E1111117E;
			7'd34: g = 40'h7F49494936;
			7'd35: g = 40'h3E41414122;
			7'd36: g = 40'h7F4141221C;
			7'd37: g = 40'h7F49494941;
			7'd38: g = 40'h7F09090901;
			7'd39: g = 40'h3E4149497A;
			7'd40: g = 40'h7F0808087F;
			7'd41: g = 40'h00417F4100;
			7'd42: g = 40'h2040413F01;
			7'd43: g = 40'h7F08142241;
			7'd44: g = 40'h7F40404040;
			7'd45: g = 40'h7F020C027F;
			7'd46: g = 40'h7F0408107F;
			7'd47: g = 40'h3E4141413E;
			7'd48: g = 40'h7F09090906;
			7'd49: g = 40'h3E4151215E;
			7'd50: g = 40'h7F09192946;
			7'd51: g = 40'h4649494931;
			7'd52: g = 40'h01017F0101;
			7'd53: g = 40'h3F4040403F;
			7'd54: g = 40'h1F2040201F;
			7'd55: g = 40'h3F4038403F;
			7'd56: g = 40'h6314081463;
			7'd57: g = 40'h0708700807;
			7'd58: g = 40'h6151494543;
			7'd59: g = 40'h007F414100;
			7'd60: g = 40'h0204081020;
			7'd61: g = 40'h0041417F00;
			7'd62: g = 40'h0402010204;
			7'd63: g = 40'h4040404040;
			7'd64: g = 40'h0001020400;
			7'd65: g = 40'h2054545478;
			7'd66: g = 40'h7F48444438;
			7'd67: g = 40'h3844444420;
			7'd68: g = 40'h384444487F;
			7'd69: g = 40'h3854545418;
			7'd70: g = 40'h087E090102;
			7'd71: g = 40'h0C5252523E;
			7'd72: g = 40'h7F08040478;
			7'd73: g = 40'h00447D4000;
			7'd74: g = 40'h2040443D00;
			7'd75: g = 40'h7F10284400;
			7'd76: g = 40'h00417F4000;
			7'd77: g = 40'h7C04180478;
			7'd78: g = 40'h7C08040478;
			7'd79: g = 40'h3844444438;
			7'd80: g = 40'h7C14141408;
			7'd81: g = 40'h081414187C;
			7'd82: g = 40'h7C08040408;
			7'd83: g = 40'h4854545420;
			7'd84: g = 40'h043F444020;
			7'd85: g = 40'h3C4040207C;
			7'd86: g = 40'h1C2040201C;
			7'd87: g = 40'h3C4030403C;
			7'd88: g = 40'h4428102844;
			7'd89: g = 40'h0C5050503C;
			7'd90: g = 40'h4464544C44;
			7'd91: g = 40'h0008364100;
			7'd92: g = 40'h00007F0000;
			7'd93: g = 40'h0041360800;
			7'd94: g = 40'h0804081008;
			default: g = 40'h0000000000;
		endcase
		return g;
	endfunction

endpackage

// ===== design/sgr_front.sv =====
module sgr_front #(
	parameter int SCREEN_WIDTH = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int MAX_SCALE = 3
) (
	input  logic                 req_valid,
	output logic                 req_ready,
	input  sgr_pkg::sgr_req_t    req,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output sgr_pkg::sgr_cmd_t    cmd
);

	logic [1:0] sc;
	logic [6:0] idx;
	logic [4:0] cw;
	logic [4:0] ch;
	logic [10:0] xe;
	logic [10:0] ye;
	logic rej;

	always_comb begin
		if (req.magnify == 8'd0) begin
			sc = 2'd1;
		end else if (req.magnify > 8'(MAX_SCALE)) begin
			sc = 2'(MAX_SCALE);
		end else begin
			sc = req.magnify[1:0];
		end
		if (req.char_code < sgr_pkg::CHAR_FIRST || req.char_code > sgr_pkg::CHAR_LAST) begin
			idx = sgr_pkg::QMARK_IDX;
		end else begin
			idx = 7'(req.char_code - sgr_pkg::CHAR_FIRST);
		end
	end

	assign cw = {2'b00, sc, 1'b0} + {1'b0, sc, 2'b00};
	assign ch = {sc, 3'b000};
	assign xe = {1'b0, req.pos_x} + {6'd0, cw};
	assign ye = {1'b0, req.pos_y} + {6'd0, ch};
	assign rej = (req.pos_x >= 10'(SCREEN_WIDTH)) || (req.pos_y >= 10'(SCREEN_HEIGHT))
		|| (xe > 11'(SCREEN_WIDTH)) || (ye > 11'(SCREEN_HEIGHT));

	always_comb begin
		cmd.rej = rej;
		cmd.sc = sc;
		cmd.glyph = sgr_pkg::glyph_rom(idx);
		cmd.x0 = req.pos_x;
		cmd.y0 = req.pos_y;
		cmd.x1 = xe[9:0] - 10'd1;
		cmd.y1 = ye[9:0] - 10'd1;
		cmd.fg = req.fg_color;
		cmd.bg = req.bg_color;
	end

	assign cmd_valid = req_valid;
	assign req_ready = cmd_ready;

endmodule

// ===== design/sgr_fifo.sv =====
module sgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/sgr_back.sv =====
module sgr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  sgr_pkg::sgr_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sgr_pkg::sgr_rsp_t rsp
);

	sgr_pkg::sgr_cmd_t cmd_q;
	sgr_pkg::sgr_rsp_t rsp_q;
	sgr_pkg::sgr_rsp_t word;
	logic busy_q;
	logic rsp_valid_q;
	logic [1:0] s_q;
	logic [2:0] frow_q;
	logic [4:0] r_q;
	logic [17:0] mask;
	logic [4:0] cw;
	logic last_row;
	logic emit;
	logic fin;
	logic pop;

	assign cw = {2'b00, cmd_q.sc, 1'b0} + {1'b0, cmd_q.sc, 2'b00};
	assign last_row = (s_q == cmd_q.sc - 2'd1) && (frow_q == 3'(sgr_pkg::FONT_ROWS - 1));
	assign emit = busy_q && (!rsp_valid_q || rsp_ready);
	assign fin = emit && (cmd_q.rej || last_row);
	assign cmd_ready = !busy_q || fin;
	assign pop = cmd_valid && cmd_ready;

	// Each font column is repeated scale times; the sixth cell column stays background.
	always_comb begin
		logic b;
		mask = '0;
		for (int c = 0; c < sgr_pkg::FONT_COLS; c++) begin
			b = cmd_q.glyph[(sgr_pkg::FONT_COLS - 1 - c) * 8 + int'(frow_q)];
			unique case (cmd_q.sc)
				2'd1: mask[c] = b;
				2'd2: mask[2 * c +: 2] = {2{b}};
				2'd3: mask[3 * c +: 3] = {3{b}};
				default: mask = '0;
			endcase
		end
	end

	always_comb begin
		word = '0;
		word.last = 1'b1;
		if (!cmd_q.rej) begin
			word.accepted = 1'b1;
			word.win_x0 = cmd_q.x0;
			word.win_y0 = cmd_q.y0;
			word.win_x1 = cmd_q.x1;
			word.win_y1 = cmd_q.y1;
			word.row_index = r_q;
			word.row_mask = mask;
			word.row_width = cw;
			word.out_fg = cmd_q.fg;
			word.out_bg = cmd_q.bg;
			word.last = last_row;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		if (emit) begin
			rsp_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			s_q <= '0;
			frow_q <= '0;
			r_q <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				s_q <= '0;
				frow_q <= '0;
				r_q <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				r_q <= r_q + 5'd1;
				if (s_q == cmd_q.sc - 2'd1) begin
					s_q <= '0;
					frow_q <= frow_q + 3'd1;
				end else begin
					s_q <= s_q + 2'd1;
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== design/scaled_glyph_rasterizer_core.sv =====
// Character cell rasterizer for a small RGB565 panel.
// The req channel takes one word per character: code, top-left position, the two
// colors and a scale. The rsp channel returns one word per display row of the
// magnified 6x8 cell, each with the drawing window, an 18-bit foreground mask and
// the colors; the final row of a character carries last. A cell that does not fit
// on the screen yields a single word with accepted low and last high.
// The front classifies and looks up the glyph in the same cycle a word is taken,
// then parks it in a two-entry queue. While the receiver takes words, the back
// steps one display row per cycle into an output register. A character passes
// from its queue entry through the back's command register to the output register.
// The row stepping of the back sets the throughput.
// When the receiver stalls, the output register holds its word, the back stops,
// and the queue keeps taking characters until it is full.
// Reset clears the queue and all valid flags; no words are pending afterward.
module scaled_glyph_rasterizer_core #(
	parameter int SCREEN_WIDTH = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int MAX_SCALE = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sgr_pkg::sgr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sgr_pkg::sgr_rsp_t rsp
);

	localparam int CMD_W = $bits(sgr_pkg::sgr_cmd_t);

	sgr_pkg::sgr_cmd_t f_cmd;
	sgr_pkg::sgr_cmd_t b_cmd;
	logic f_valid;
	logic f_ready;
	logic b_valid;
	logic b_ready;
	logic [CMD_W-1:0] b_bits;

	sgr_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	sgr_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(f_cmd),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(b_bits)
	);

	assign b_cmd = sgr_pkg::sgr_cmd_t'(b_bits);

	sgr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd(b_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule
